// ===== rtl/zyz_euler_to_rotation_matrix_defines.svh =====
// assertion macros for the euler to rotation matrix block
`ifndef ZYZ_EULER_TO_ROTATION_MATRIX_DEFINES_SVH
`define ZYZ_EULER_TO_ROTATION_MATRIX_DEFINES_SVH

`ifndef ASSERT_OFF
`define ZYZ_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("zyz assertion failed");
`define ZYZ_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("zyz assertion failed");
`else
`define ZYZ_ASSERT_IMP(label, ante, cons)
`define ZYZ_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/zyz_pkg.sv =====
package zyz_pkg;

   typedef logic signed [31:0] trig_type;

   typedef enum logic [1:0] {
      QUAD_I,
      QUAD_II,
      QUAD_III,
      QUAD_IV
   } quadrant_type;

   typedef struct packed {
      logic         swap;
      quadrant_type quad;
   } octant_type;

   typedef struct packed {
      trig_type sa;
      trig_type ca;
      trig_type sb;
      trig_type cb;
      trig_type sg;
      trig_type cg;
   } trig_set_type;

   localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
   localparam logic [29:0] OCTANT_MAX = 30'h2000_0000;
   localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

   // horner divisors, sine lane then cosine lane
   localparam logic [6:0] HORNER_DIV [2][4] = '{
      '{7'd72, 7'd42, 7'd20, 7'd6},
      '{7'd56, 7'd30, 7'd12, 7'd2}
   };

   localparam logic [29:0] HORNER_RECIP [2][4] = '{
      '{30'((1 << 30) / 72), 30'((1 << 30) / 42), 30'((1 << 30) / 20), 30'((1 << 30) / 6)},
      '{30'((1 << 30) / 56), 30'((1 << 30) / 30), 30'((1 << 30) / 12), 30'((1 << 30) / 2)}
   };

   function automatic logic [30:0] umul_q30(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] prod;
      prod = a * b;
      return prod[60:30];
   endfunction

   // quotient estimate, low by at most one
   function automatic logic [30:0] quot_est(input logic [30:0] v, input logic [29:0] m);
      logic [60:0] prod;
      prod = v * m;
      return prod[60:30];
   endfunction

   function automatic logic [30:0] quot_fix(input logic [30:0] v, input logic [30:0] qe,
                                            input logic [6:0] d);
      logic [37:0] qd;
      logic [30:0] r;
      qd = qe * d;
      r  = v - qd[30:0];
      return (r >= {24'd0, d}) ? qe + 31'd1 : qe;
   endfunction

endpackage

// ===== rtl/zyz_euler_to_rotation_matrix.sv =====
// channel   direction  handshake                 payload
// req       in         req_valid / req_stall     req_angle_alpha/beta/gamma, req_proper_flag
// rsp       out        rsp_valid / rsp_stall     rsp_elem_00 .. rsp_elem_22
//
// one request per cycle unless a stalled result holds the pipeline
// the result path is the 16-stage sine/cosine horner pipeline followed by 7 matrix stages
// synchronous reset clears the valid bits only
// a stalled result freezes the whole pipeline; bubbles are not squeezed out
`include "zyz_euler_to_rotation_matrix_defines.svh"

module zyz_euler_to_rotation_matrix #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ANGLE_BITS-1:0]  req_angle_alpha,
   input  logic [ANGLE_BITS-1:0]  req_angle_beta,
   input  logic [ANGLE_BITS-1:0]  req_angle_gamma,
   input  logic                   req_proper_flag,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [FRAC_BITS+1:0] rsp_elem_00,
   output logic signed [FRAC_BITS+1:0] rsp_elem_01,
   output logic signed [FRAC_BITS+1:0] rsp_elem_02,
   output logic signed [FRAC_BITS+1:0] rsp_elem_10,
   output logic signed [FRAC_BITS+1:0] rsp_elem_11,
   output logic signed [FRAC_BITS+1:0] rsp_elem_12,
   output logic signed [FRAC_BITS+1:0] rsp_elem_20,
   output logic signed [FRAC_BITS+1:0] rsp_elem_21,
   output logic signed [FRAC_BITS+1:0] rsp_elem_22
);
   import zyz_pkg::*;

   localparam int          LAT       = 23;
   localparam int          OUT_BITS  = FRAC_BITS + 2;
   localparam int          OUT_SHIFT = 30 - FRAC_BITS;
   localparam logic [32:0] HALF      = (33'd1 << OUT_SHIFT) >> 1;
   localparam logic [32:0] LIM       = 33'd1 << FRAC_BITS;
   localparam logic signed [OUT_BITS-1:0] ELEM_MAX = OUT_BITS'(LIM);
   localparam logic signed [OUT_BITS-1:0] ELEM_MIN = -ELEM_MAX;

   logic                       advance;
   logic [LAT:1]               vld_ff;
   logic [21:1]                flag_ff;
   trig_set_type               trig_in;
   trig_set_type               trig_ff [17:18];
   trig_type                   cb_ff   [19:20];
   trig_type                   cbcg;
   trig_type                   cbsg;
   trig_type                   mb_a    [12];
   trig_type                   mb_b    [12];
   trig_type                   mb_p    [12];
   logic signed [32:0]         sum_in  [9];
   logic signed [32:0]         sum_ff  [9];
   logic [32:0]                mag_ff  [9];
   logic                       sgn_ff  [9];
   logic [32:0]                rnd     [9];
   logic [32:0]                sat     [9];
   logic signed [OUT_BITS-1:0] elem_ff [9];

   assign advance   = !(vld_ff[LAT] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LAT-1:1], req_valid};
      end
   end

   zyz_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_alpha (
      .clock(clock), .enable(advance), .angle(req_angle_alpha),
      .sin_out(trig_in.sa), .cos_out(trig_in.ca)
   );
   zyz_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_beta (
      .clock(clock), .enable(advance), .angle(req_angle_beta),
      .sin_out(trig_in.sb), .cos_out(trig_in.cb)
   );
   zyz_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_gamma (
      .clock(clock), .enable(advance), .angle(req_angle_gamma),
      .sin_out(trig_in.sg), .cos_out(trig_in.cg)
   );

   zyz_mulq u_cbcg (.clock(clock), .enable(advance), .a(trig_in.cb), .b(trig_in.cg),
                    .prod(cbcg));
   zyz_mulq u_cbsg (.clock(clock), .enable(advance), .a(trig_in.cb), .b(trig_in.sg),
                    .prod(cbsg));

   assign mb_a[0]  = trig_ff[18].ca;  assign mb_b[0]  = cbcg;
   assign mb_a[1]  = trig_ff[18].sa;  assign mb_b[1]  = cbcg;
   assign mb_a[2]  = trig_ff[18].ca;  assign mb_b[2]  = cbsg;
   assign mb_a[3]  = trig_ff[18].sa;  assign mb_b[3]  = cbsg;
   assign mb_a[4]  = trig_ff[18].sa;  assign mb_b[4]  = trig_ff[18].sg;
   assign mb_a[5]  = trig_ff[18].ca;  assign mb_b[5]  = trig_ff[18].sg;
   assign mb_a[6]  = trig_ff[18].sb;  assign mb_b[6]  = trig_ff[18].cg;
   assign mb_a[7]  = trig_ff[18].sa;  assign mb_b[7]  = trig_ff[18].cg;
   assign mb_a[8]  = trig_ff[18].ca;  assign mb_b[8]  = trig_ff[18].cg;
   assign mb_a[9]  = trig_ff[18].sb;  assign mb_b[9]  = trig_ff[18].sg;
   assign mb_a[10] = trig_ff[18].ca;  assign mb_b[10] = trig_ff[18].sb;
   assign mb_a[11] = trig_ff[18].sa;  assign mb_b[11] = trig_ff[18].sb;

   for (genvar i = 0; i < 12; i++) begin : g_mul
      zyz_mulq u_mul (.clock(clock), .enable(advance), .a(mb_a[i]), .b(mb_b[i]),
                      .prod(mb_p[i]));
   end

   assign sum_in[0] = 33'(mb_p[0]) - 33'(mb_p[4]);
   assign sum_in[1] = 33'(mb_p[1]) + 33'(mb_p[5]);
   assign sum_in[2] = -33'(mb_p[6]);
   assign sum_in[3] = -33'(mb_p[2]) - 33'(mb_p[7]);
   assign sum_in[4] = 33'(mb_p[8]) - 33'(mb_p[3]);
   assign sum_in[5] = 33'(mb_p[9]);
   assign sum_in[6] = 33'(mb_p[10]);
   assign sum_in[7] = 33'(mb_p[11]);
   assign sum_in[8] = 33'(cb_ff[20]);

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         rnd[i] = (mag_ff[i] + HALF) >> OUT_SHIFT;
         sat[i] = (rnd[i] > LIM) ? LIM : rnd[i];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flag_ff    <= {flag_ff[20:1], req_proper_flag};
         trig_ff[17] <= trig_in;
         trig_ff[18] <= trig_ff[17];
         cb_ff[19]   <= trig_ff[18].cb;
         cb_ff[20]   <= cb_ff[19];
         for (int i = 0; i < 9; i++) begin
            sum_ff[i]  <= sum_in[i];
            mag_ff[i]  <= sum_ff[i][32] ? 33'(-sum_ff[i]) : 33'(sum_ff[i]);
            sgn_ff[i]  <= sum_ff[i][32] ^ !flag_ff[21];
            elem_ff[i] <= sgn_ff[i] ? -OUT_BITS'(sat[i]) : OUT_BITS'(sat[i]);
         end
      end
   end

   assign rsp_elem_00 = elem_ff[0];
   assign rsp_elem_01 = elem_ff[1];
   assign rsp_elem_02 = elem_ff[2];
   assign rsp_elem_10 = elem_ff[3];
   assign rsp_elem_11 = elem_ff[4];
   assign rsp_elem_12 = elem_ff[5];
   assign rsp_elem_20 = elem_ff[6];
   assign rsp_elem_21 = elem_ff[7];
   assign rsp_elem_22 = elem_ff[8];

   `ZYZ_ASSERT_IMP(a_stall_only_when_blocked, req_stall, rsp_valid && rsp_stall)
   `ZYZ_ASSERT_NXT(a_pipe_frozen, req_stall, $stable(vld_ff))
   `ZYZ_ASSERT_IMP(a_e22_in_range, rsp_valid, (rsp_elem_22 <= ELEM_MAX) && (rsp_elem_22 >= ELEM_MIN))

endmodule

// ===== rtl/zyz_sincos.sv =====
module zyz_sincos #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [ANGLE_BITS-1:0] angle,
   output zyz_pkg::trig_type     sin_out,
   output zyz_pkg::trig_type     cos_out
);
   import zyz_pkg::*;

   logic [31:0] turn;
   logic [29:0] rem;
   logic        swap_in;
   logic [30:0] arg_in;
   logic [62:0] xprod;

   logic [30:0] arg_ff;
   octant_type  ctl_ff [1:15];
   logic [30:0] x_ff   [2:14];
   logic [30:0] x2_ff  [3:11];
   logic [30:0] qe0_ff [2];
   logic [30:0] h_ff   [2][4];
   logic [30:0] p_ff   [2][1:3];
   logic [30:0] pd_ff  [2][1:3];
   logic [30:0] qe_ff  [2][1:3];
   logic [30:0] s_ff;
   logic [30:0] c_ff;
   trig_type    s0;
   trig_type    c0;
   trig_type    sin_ff;
   trig_type    cos_ff;

   assign turn    = 32'(angle) << (32 - ANGLE_BITS);
   assign rem     = turn[29:0];
   assign swap_in = rem > OCTANT_MAX;
   assign arg_in  = swap_in ? (Q30_ONE - {1'b0, rem}) : {1'b0, rem};
   assign xprod   = arg_ff * TWO_PI_Q29;

   assign s0 = ctl_ff[15].swap ? trig_type'({1'b0, c_ff}) : trig_type'({1'b0, s_ff});
   assign c0 = ctl_ff[15].swap ? trig_type'({1'b0, s_ff}) : trig_type'({1'b0, c_ff});

   always_ff @(posedge clock) begin
      if (enable) begin
         arg_ff    <= arg_in;
         ctl_ff[1] <= '{swap: swap_in, quad: quadrant_type'(turn[31:30])};
         for (int k = 2; k <= 15; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
         x_ff[2] <= xprod[61:31];
         for (int k = 3; k <= 14; k++) begin
            x_ff[k] <= x_ff[k-1];
         end
         x2_ff[3] <= umul_q30(x_ff[2], x_ff[2]);
         for (int k = 4; k <= 11; k++) begin
            x2_ff[k] <= x2_ff[k-1];
         end
         for (int l = 0; l < 2; l++) begin
            qe0_ff[l]  <= quot_est(x2_ff[3], HORNER_RECIP[l][0]);
            h_ff[l][0] <= Q30_ONE - quot_fix(x2_ff[4], qe0_ff[l], HORNER_DIV[l][0]);
            for (int j = 1; j < 4; j++) begin
               p_ff[l][j]  <= umul_q30(x2_ff[3*j+2], h_ff[l][j-1]);
               pd_ff[l][j] <= p_ff[l][j];
               qe_ff[l][j] <= quot_est(p_ff[l][j], HORNER_RECIP[l][j]);
               h_ff[l][j]  <= Q30_ONE - quot_fix(pd_ff[l][j], qe_ff[l][j], HORNER_DIV[l][j]);
            end
         end
         s_ff <= umul_q30(x_ff[14], h_ff[0][3]);
         c_ff <= h_ff[1][3];
         case (ctl_ff[15].quad)
            QUAD_I: begin
               sin_ff <= s0;
               cos_ff <= c0;
            end
            QUAD_II: begin
               sin_ff <= c0;
               cos_ff <= -s0;
            end
            QUAD_III: begin
               sin_ff <= -s0;
               cos_ff <= -c0;
            end
            default: begin
               sin_ff <= -c0;
               cos_ff <= s0;
            end
         endcase
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

// ===== rtl/zyz_mulq.sv =====
module zyz_mulq (
   input  logic              clock,
   input  logic              enable,
   input  zyz_pkg::trig_type a,
   input  zyz_pkg::trig_type b,
   output zyz_pkg::trig_type prod
);
   import zyz_pkg::*;

   localparam logic [61:0] ROUND_HALF = 62'h2000_0000;

   logic [31:0] ua;
   logic [31:0] ub;
   logic [61:0] prod_in;
   logic [61:0] rnd;
   logic [61:0] prod_ff;
   logic        neg_ff;
   trig_type    out_ff;

   assign ua      = a[31] ? 32'(-a) : 32'(a);
   assign ub      = b[31] ? 32'(-b) : 32'(b);
   assign prod_in = ua[30:0] * ub[30:0];
   assign rnd     = prod_ff + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         neg_ff  <= a[31] ^ b[31];
         out_ff  <= neg_ff ? -trig_type'(rnd[61:30]) : trig_type'(rnd[61:30]);
      end
   end

   assign prod = out_ff;

endmodule

// ===== bench/zyz_euler_to_rotation_matrix_tb.sv =====
`timescale 1ns / 100ps

module zyz_euler_to_rotation_matrix_tb;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 14;
   localparam int OUT_BITS   = FRAC_BITS + 2;
   localparam int RANDOM_REQUESTS = 700;
   localparam int LATENCY = 23;
   localparam longint CYCLE_LIMIT = 200000;
   localparam longint Q30_ONE = 64'd1 << 30;
   localparam longint TWO_PI_Q29 = 64'd3373259426;

   typedef logic signed [OUT_BITS-1:0] elem_type;
   typedef struct {
      elem_type e [9];
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ANGLE_BITS-1:0] req_angle_alpha = '0;
   logic [ANGLE_BITS-1:0] req_angle_beta = '0;
   logic [ANGLE_BITS-1:0] req_angle_gamma = '0;
   logic req_proper_flag = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   elem_type rsp_elem_00, rsp_elem_01, rsp_elem_02, rsp_elem_10, rsp_elem_11;
   elem_type rsp_elem_12, rsp_elem_20, rsp_elem_21, rsp_elem_22;

   matrix_type expected_matrices[$];
   int mismatches = 0;
   int requests_sent = 0;
   int results_checked = 0;
   int improper_sent = 0;
   bit idle_enable = 1'b1;
   longint cycles = 0;

   zyz_euler_to_rotation_matrix #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_angle_alpha(req_angle_alpha), .req_angle_beta(req_angle_beta),
      .req_angle_gamma(req_angle_gamma), .req_proper_flag(req_proper_flag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_elem_00(rsp_elem_00), .rsp_elem_01(rsp_elem_01), .rsp_elem_02(rsp_elem_02),
      .rsp_elem_10(rsp_elem_10), .rsp_elem_11(rsp_elem_11), .rsp_elem_12(rsp_elem_12),
      .rsp_elem_20(rsp_elem_20), .rsp_elem_21(rsp_elem_21), .rsp_elem_22(rsp_elem_22)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= idle_enable && ($urandom_range(99) < 33);
      end
   end

   function automatic void octant_sin_cos(input longint unsigned t,
                                          output longint unsigned s,
                                          output longint unsigned c);
      longint unsigned x, x2, h;
      x = (t * TWO_PI_Q29) >> 31;
      x2 = (x * x) >> 30;
      h = Q30_ONE - x2 / 72;
      h = Q30_ONE - ((x2 * h) >> 30) / 42;
      h = Q30_ONE - ((x2 * h) >> 30) / 20;
      h = Q30_ONE - ((x2 * h) >> 30) / 6;
      s = (x * h) >> 30;
      h = Q30_ONE - x2 / 56;
      h = Q30_ONE - ((x2 * h) >> 30) / 30;
      h = Q30_ONE - ((x2 * h) >> 30) / 12;
      c = Q30_ONE - ((x2 * h) >> 30) / 2;
   endfunction

   function automatic void turn_sin_cos(input logic [ANGLE_BITS-1:0] a,
                                        output longint sn, output longint cs);
      logic [31:0] t;
      longint unsigned r, s0, c0;
      t = {a, {(32 - ANGLE_BITS){1'b0}}};
      r = t[29:0];
      if (r <= (Q30_ONE >> 1)) begin
         octant_sin_cos(r, s0, c0);
      end else begin
         octant_sin_cos(Q30_ONE - r, c0, s0);
      end
      case (t[31:30])
         2'd0: begin sn = s0;  cs = c0;  end
         2'd1: begin sn = c0;  cs = -s0; end
         2'd2: begin sn = -s0; cs = -c0; end
         default: begin sn = -c0; cs = s0; end
      endcase
   endfunction

   function automatic longint q30_product(input longint a, input longint b);
      longint unsigned ua, ub, m;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      m = (ua * ub + (Q30_ONE >> 1)) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic elem_type round_element(input longint v, input bit negate);
      longint unsigned mag;
      bit neg;
      neg = v < 0;
      mag = neg ? -v : v;
      mag = (mag + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (mag > (64'd1 << FRAC_BITS)) mag = 64'd1 << FRAC_BITS;
      if (negate) neg = !neg;
      return neg ? elem_type'(-longint'(mag)) : elem_type'(mag);
   endfunction

   function automatic matrix_type rotation_matrix(input logic [ANGLE_BITS-1:0] al,
                                                  input logic [ANGLE_BITS-1:0] be,
                                                  input logic [ANGLE_BITS-1:0] ga,
                                                  input logic proper);
      longint sa, ca, sb, cb, sg, cg, cbcg, cbsg;
      longint v [9];
      matrix_type m;
      turn_sin_cos(al, sa, ca);
      turn_sin_cos(be, sb, cb);
      turn_sin_cos(ga, sg, cg);
      cbcg = q30_product(cb, cg);
      cbsg = q30_product(cb, sg);
      v[0] = q30_product(ca, cbcg) - q30_product(sa, sg);
      v[1] = q30_product(sa, cbcg) + q30_product(ca, sg);
      v[2] = -q30_product(sb, cg);
      v[3] = -q30_product(ca, cbsg) - q30_product(sa, cg);
      v[4] = -q30_product(sa, cbsg) + q30_product(ca, cg);
      v[5] = q30_product(sb, sg);
      v[6] = q30_product(ca, sb);
      v[7] = q30_product(sa, sb);
      v[8] = cb;
      for (int i = 0; i < 9; i++) m.e[i] = round_element(v[i], !proper);
      return m;
   endfunction

   always @(posedge clock) begin
      matrix_type want;
      elem_type got [9];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_elem_00, rsp_elem_01, rsp_elem_02, rsp_elem_10, rsp_elem_11,
                 rsp_elem_12, rsp_elem_20, rsp_elem_21, rsp_elem_22};
         if (expected_matrices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
         end else begin
            want = expected_matrices.pop_front();
            results_checked++;
            for (int i = 0; i < 9; i++) begin
               if (got[i] !== want.e[i]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d elem_%0d%0d: expected %0d got %0d",
                              results_checked, i / 3, i % 3, want.e[i], got[i]);
               end
            end
         end
      end
   end

   task automatic send_request(input logic [ANGLE_BITS-1:0] al,
                               input logic [ANGLE_BITS-1:0] be,
                               input logic [ANGLE_BITS-1:0] ga,
                               input logic proper);
      while (idle_enable && ($urandom_range(99) < 33)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_angle_alpha <= al;
      req_angle_beta <= be;
      req_angle_gamma <= ga;
      req_proper_flag <= proper;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_matrices.push_back(rotation_matrix(al, be, ga, proper));
      requests_sent++;
      if (!proper) improper_sent++;
   endtask

   task automatic test_directed_angles();
      logic [ANGLE_BITS-1:0] corners [8] = '{16'h0000, 16'hFFFF, 16'h2000, 16'h4000,
                                             16'h8000, 16'hC000, 16'h1FFF, 16'h6001};
      for (int i = 0; i < 8; i++) begin
         send_request(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8], i[0]);
      end
      send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_request(16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_request(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
      send_request(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
      send_request(16'h2001, 16'h1FFF, 16'hE000, 1'b1);
   endtask

   task automatic test_random_angles();
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         idle_enable = !(n >= 200 && n < 300);
         if ($urandom_range(3) == 0)
            send_request(16'($urandom_range(7)) << 13, 16'($urandom()), 16'($urandom()),
                         1'($urandom()));
         else
            send_request(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'($urandom()));
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_angles();
      test_random_angles();
      req_valid <= 1'b0;
      while (expected_matrices.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("checked %0d matrices from %0d requests, %0d of them improper",
               results_checked, requests_sent, improper_sent);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatching fields", mismatches);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
